// ===== hdl/cpu_data_transfer_executor_unit_macros.svh =====
// Assertion macros for the data-transfer executor
`ifndef CPU_DATA_TRANSFER_EXECUTOR_UNIT_MACROS_SVH
`define CPU_DATA_TRANSFER_EXECUTOR_UNIT_MACROS_SVH

// Implication check, sampled on clk, off during reset
`define CDTE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check, sampled on clk, off during reset
`define CDTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cdte_pkg.sv =====
package cdte_pkg;

  localparam int ADDR_BITS_DEF = 16;

  // command codes
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_STEP    = 2'd2;
  localparam logic [1:0] CMD_RESTART = 2'd3;

  // opcodes
  localparam logic [7:0] OP_HLT  = 8'h76;
  localparam logic [7:0] OP_MVIM = 8'h36;
  localparam logic [7:0] OP_LXIB = 8'h01;
  localparam logic [7:0] OP_LXID = 8'h11;
  localparam logic [7:0] OP_LXIH = 8'h21;
  localparam logic [7:0] OP_LXIS = 8'h31;
  localparam logic [7:0] OP_STA  = 8'h32;
  localparam logic [7:0] OP_LDA  = 8'h3A;
  localparam logic [7:0] OP_LHLD = 8'h2A;
  localparam logic [7:0] OP_SHLD = 8'h22;
  localparam logic [7:0] OP_SPHL = 8'hF9;
  localparam logic [7:0] OP_PCHL = 8'hE9;

  // register codes
  localparam logic [2:0] RC_M = 3'd6;
  localparam logic [2:0] RC_A = 3'd7;

  // memory address source
  typedef enum logic [2:0] {
    AS_CMD  = 3'd0,
    AS_PC   = 3'd1,
    AS_HL   = 3'd2,
    AS_W    = 3'd3,
    AS_W1   = 3'd4,
    AS_PC1  = 3'd5   // byte after the one pc points at
  } asel_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    DO_NONE    = 4'd0,
    DO_RESTART = 4'd1,
    DO_LATCH_OP = 4'd2,  // opcode from mem, pc++
    DO_LATCH_LO = 4'd3,  // lo from mem, pc++
    DO_LATCH_HI = 4'd4,  // hi from mem, pc++
    DO_MVI     = 4'd5,   // dst reg <= mem data, pc++
    DO_MOV     = 4'd6,   // dst reg <= src reg
    DO_MOV_MEM = 4'd7,   // dst reg <= mem data
    DO_WIDE    = 4'd8,   // LXI, SPHL, PCHL
    DO_LDA     = 4'd9,
    DO_LHLD_L  = 4'd10,
    DO_LHLD_H  = 4'd11,
    DO_HALT    = 4'd12,
    DO_READ    = 4'd13,
    DO_LEN     = 4'd14   // set halt if pc >= length
  } dop_t;

  typedef struct packed {
    logic        mem_we;
    asel_t       asel;
    logic [1:0]  wsel;   // 0 cmd byte, 1 src reg, 2 L, 3 H / A
    dop_t        op;
    logic        done;
  } dp_cmd_t;

  typedef struct packed {
    logic [7:0] opcode;
    logic       halted;
    logic       at_end;
  } dp_stat_t;

endpackage

// ===== hdl/cdte_ram.sv =====
module cdte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/cdte_datapath.sv =====
module cdte_datapath
  import cdte_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [16:0] len,
  input  logic [15:0] address,
  input  logic [7:0]  write_byte,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic [7:0]  read_byte,
  output logic [15:0] pc_value,
  output logic [7:0]  reg_a,
  output logic [15:0] reg_bc,
  output logic [15:0] reg_de,
  output logic [15:0] reg_hl,
  output logic [15:0] stack_pointer,
  output logic        halted
);

  logic [ADDR_BITS-1:0] pc, sp;
  logic [7:0] regs [7];
  logic [7:0] opcode, lo, hi, rbyte;
  logic       halt;
  logic [ADDR_BITS-1:0] maddr, wadr, hladr;
  logic [7:0] wdata, rdata, src;
  logic [ADDR_BITS-1:0] pc_inc;
  logic [2:0] dst, srcc;

  assign wadr   = ADDR_BITS'({hi, lo});
  assign hladr  = ADDR_BITS'({regs[4], regs[5]});
  assign pc_inc = pc + ADDR_BITS'(1);
  assign dst    = opcode[5:3];
  assign srcc   = opcode[2:0];
  assign src    = (srcc == RC_A) ? regs[6] : regs[srcc];

  // memory address mux
  always_comb begin
    case (cmd.asel)
      AS_CMD:  maddr = address[ADDR_BITS-1:0];
      AS_PC:   maddr = pc;
      AS_PC1:  maddr = pc_inc;
      AS_HL:   maddr = hladr;
      AS_W:    maddr = wadr;
      AS_W1:   maddr = wadr + ADDR_BITS'(1);
      default: maddr = pc;
    endcase
  end

  // memory write data mux
  always_comb begin
    case (cmd.wsel)
      2'd0:    wdata = write_byte;
      2'd1:    wdata = src;
      2'd2:    wdata = regs[5];
      default: wdata = (opcode == OP_STA) ? regs[6] : regs[4];
    endcase
  end

  cdte_ram #(.WIDTH(8), .DEPTH(1 << ADDR_BITS)) u_ram (
    .clk   (clk),
    .we    (cmd.mem_we),
    .addr  (maddr),
    .wdata (wdata),
    .rdata (rdata)
  );

  // register file and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= '0;
      sp    <= '0;
      halt  <= 1'b0;
      rbyte <= '0;
      for (int i = 0; i < 7; i++) regs[i] <= '0;
    end else begin
      case (cmd.op)
        DO_RESTART: begin
          pc   <= '0;
          sp   <= '0;
          halt <= 1'b0;
          for (int i = 0; i < 7; i++) regs[i] <= '0;
        end
        DO_LATCH_OP: begin
          opcode <= rdata;
          pc     <= pc_inc;
        end
        DO_LATCH_LO: begin
          lo <= rdata;
          pc <= pc_inc;
        end
        DO_LATCH_HI: begin
          hi <= rdata;
          pc <= pc_inc;
        end
        DO_MVI: begin
          pc <= pc_inc;
          if (dst == RC_A) regs[6] <= rdata;
          else regs[dst] <= rdata;
        end
        DO_MOV: begin
          if (dst == RC_A) regs[6] <= src;
          else regs[dst] <= src;
        end
        DO_MOV_MEM: begin
          if (dst == RC_A) regs[6] <= rdata;
          else regs[dst] <= rdata;
        end
        DO_WIDE: begin
          case (opcode)
            OP_LXIB: begin regs[0] <= hi; regs[1] <= lo; end
            OP_LXID: begin regs[2] <= hi; regs[3] <= lo; end
            OP_LXIH: begin regs[4] <= hi; regs[5] <= lo; end
            OP_LXIS: sp <= wadr;
            OP_SPHL: sp <= hladr;
            OP_PCHL: pc <= hladr;
            default: ;
          endcase
        end
        DO_LDA:    regs[6] <= rdata;
        DO_LHLD_L: regs[5] <= rdata;
        DO_LHLD_H: regs[4] <= rdata;
        DO_HALT:   halt <= 1'b1;
        DO_READ:   rbyte <= rdata;
        DO_LEN:    if (17'(pc) >= len) halt <= 1'b1;
        default: ;
      endcase
      if (cmd.done && cmd.op != DO_READ) rbyte <= '0;
    end
  end

  assign stat.opcode = opcode;
  assign stat.halted = halt;
  assign stat.at_end = (17'(pc) >= len);

  assign read_byte     = rbyte;
  assign pc_value      = 16'(pc);
  assign reg_a         = regs[6];
  assign reg_bc        = {regs[0], regs[1]};
  assign reg_de        = {regs[2], regs[3]};
  assign reg_hl        = {regs[4], regs[5]};
  assign stack_pointer = 16'(sp);
  assign halted        = halt;

endmodule

// ===== hdl/cdte_ctrl.sv =====
module cdte_ctrl
  import cdte_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] cmd,
  input  dp_stat_t   stat,
  output dp_cmd_t    dcmd,
  output logic       busy,
  output logic       strobe
);

`include "cpu_data_transfer_executor_unit_macros.svh"

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_READ  = 11'b00000000010,
    S_OPC   = 11'b00000000100,
    S_DEC   = 11'b00000001000,
    S_LO    = 11'b00000010000,
    S_HI    = 11'b00000100000,
    S_EXE   = 11'b00001000000,
    S_MEM1  = 11'b00010000000,
    S_MEM2  = 11'b00100000000,
    S_LEN   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic   strobe_next;
  logic [7:0] op;
  logic is_mov, is_mvi, is_wide, is_abs;

  assign op      = stat.opcode;
  assign is_mov  = (op[7:6] == 2'b01) && (op != OP_HLT);
  assign is_mvi  = ((op & 8'hC7) == 8'h06) && (op != OP_MVIM);
  assign is_abs  = (op == OP_STA) || (op == OP_LDA) || (op == OP_LHLD) || (op == OP_SHLD);
  assign is_wide = (op == OP_LXIB) || (op == OP_LXID) || (op == OP_LXIH) ||
                   (op == OP_LXIS) || is_abs;

  // next state and datapath command
  always_comb begin
    state_next  = state;
    strobe_next = 1'b0;
    dcmd        = '{mem_we: 1'b0, asel: AS_PC, wsel: 2'd0, op: DO_NONE, done: 1'b0};
    case (state)
      S_IDLE: begin
        if (start) begin
          case (cmd)
            CMD_WRITE: begin
              dcmd.mem_we = 1'b1;
              dcmd.asel   = AS_CMD;
              dcmd.done   = 1'b1;
              strobe_next = 1'b1;
              state_next  = S_DONE;
            end
            CMD_READ: begin
              dcmd.asel  = AS_CMD;
              state_next = S_READ;
            end
            CMD_STEP: begin
              if (stat.halted) begin
                dcmd.done   = 1'b1;
                strobe_next = 1'b1;
                state_next  = S_DONE;
              end else if (stat.at_end) begin
                dcmd.op     = DO_HALT;
                dcmd.done   = 1'b1;
                strobe_next = 1'b1;
                state_next  = S_DONE;
              end else begin
                state_next = S_OPC;
              end
            end
            default: begin
              dcmd.op     = DO_RESTART;
              dcmd.done   = 1'b1;
              strobe_next = 1'b1;
              state_next  = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        dcmd.op     = DO_READ;
        dcmd.done   = 1'b1;
        strobe_next = 1'b1;
        state_next  = S_DONE;
      end
      S_OPC: begin
        dcmd.op    = DO_LATCH_OP;
        state_next = S_DEC;
      end
      S_DEC: begin
        // opcode known, pc points past it; issue first access
        if (op == OP_HLT) begin
          dcmd.op    = DO_HALT;
          state_next = S_LEN;
        end else if (is_mov) begin
          if (op[5:3] == RC_M && op[2:0] != RC_M) begin
            dcmd.asel   = AS_HL;
            dcmd.mem_we = 1'b1;
            dcmd.wsel   = 2'd1;
            state_next  = S_LEN;
          end else if (op[2:0] == RC_M) begin
            dcmd.asel  = AS_HL;
            state_next = S_MEM1;
          end else begin
            dcmd.op    = DO_MOV;
            state_next = S_LEN;
          end
        end else if (is_mvi) begin
          dcmd.asel  = AS_PC;
          state_next = S_MEM1;
        end else if (is_wide) begin
          dcmd.asel  = AS_PC;
          state_next = S_LO;
        end else if (op == OP_SPHL || op == OP_PCHL) begin
          dcmd.op    = DO_WIDE;
          state_next = S_LEN;
        end else begin
          state_next = S_LEN;
        end
      end
      S_MEM1: begin
        if (is_mvi) dcmd.op = DO_MVI;
        else dcmd.op = DO_MOV_MEM;
        state_next = S_LEN;
      end
      S_LO: begin
        // pc still points at the low byte; fetch the high byte behind it
        dcmd.op    = DO_LATCH_LO;
        dcmd.asel  = AS_PC1;
        state_next = S_HI;
      end
      S_HI: begin
        dcmd.op    = DO_LATCH_HI;
        state_next = S_EXE;
      end
      S_EXE: begin
        if (!is_abs) begin
          dcmd.op    = DO_WIDE;
          state_next = S_LEN;
        end else if (op == OP_STA) begin
          dcmd.asel   = AS_W;
          dcmd.mem_we = 1'b1;
          dcmd.wsel   = 2'd3;
          state_next  = S_LEN;
        end else if (op == OP_SHLD) begin
          dcmd.asel   = AS_W;
          dcmd.mem_we = 1'b1;
          dcmd.wsel   = 2'd2;
          state_next  = S_MEM2;
        end else begin
          dcmd.asel  = AS_W;
          state_next = S_MEM1;
          if (op == OP_LHLD) state_next = S_MEM2;
        end
      end
      S_MEM2: begin
        if (op == OP_SHLD) begin
          dcmd.asel   = AS_W1;
          dcmd.mem_we = 1'b1;
          dcmd.wsel   = 2'd3;
          state_next  = S_LEN;
        end else begin
          // LHLD: low byte arrives, request high byte
          dcmd.op    = DO_LHLD_L;
          dcmd.asel  = AS_W1;
          state_next = S_MEM1;
        end
      end
      S_LEN: begin
        dcmd.op     = DO_LEN;
        dcmd.done   = 1'b1;
        strobe_next = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // LDA and LHLD high byte share S_MEM1 with MOV r,M
    if (state == S_MEM1 && op == OP_LDA)  dcmd.op = DO_LDA;
    if (state == S_MEM1 && op == OP_LHLD) dcmd.op = DO_LHLD_H;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
    end
  end

  assign busy = (state != S_IDLE);

  `CDTE_ASSERT_IMP(a_strobe_done, strobe, state == S_DONE, "strobe outside done state")
  `CDTE_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command did not go busy")
  `CDTE_ASSERT_IMP(a_no_we_idle, state == S_IDLE && !start, !dcmd.mem_we, "write while idle")

endmodule

// ===== hdl/cpu_data_transfer_executor_unit.sv =====
// Data-transfer subset executor with private byte memory. Pulse start with
// cmd while busy is low; one result appears for one cycle with strobe and
// cannot be stalled, so capture it when strobe is high. Write, restart and
// a halted step are the quickest commands, then read; a step is shortest
// for a no-op, MOV between registers or to M, HLT, SPHL or PCHL and longest
// for LHLD: every opcode fetch, operand byte and data access goes through the
// single-port memory with a registered read. busy returns low in the cycle
// after strobe. Memory holds garbage until written.
module cpu_data_transfer_executor_unit
  import cdte_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic [1:0]  cmd,
  input  logic [15:0] address,
  input  logic [7:0]  write_byte,
  output logic        strobe,
  output logic [7:0]  read_byte,
  output logic [15:0] pc_value,
  output logic [7:0]  reg_a,
  output logic [15:0] reg_bc,
  output logic [15:0] reg_de,
  output logic [15:0] reg_hl,
  output logic [15:0] stack_pointer,
  output logic        halted
);

  logic [16:0] program_length;
  dp_cmd_t     dcmd;
  dp_stat_t    stat;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (cfg_we) begin
      program_length <= cfg_wdata;
    end
  end

  cdte_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .stat   (stat),
    .dcmd   (dcmd),
    .busy   (busy),
    .strobe (strobe)
  );

  cdte_datapath #(.ADDR_BITS(ADDR_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .len           (program_length),
    .address       (address),
    .write_byte    (write_byte),
    .cmd           (dcmd),
    .stat          (stat),
    .read_byte     (read_byte),
    .pc_value      (pc_value),
    .reg_a         (reg_a),
    .reg_bc        (reg_bc),
    .reg_de        (reg_de),
    .reg_hl        (reg_hl),
    .stack_pointer (stack_pointer),
    .halted        (halted)
  );

endmodule
